// ===== rtl/mish_activation_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Mish activation block
// Concurrent checks, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MISH_ACTIVATION_ASSERT_SVH
`define MISH_ACTIVATION_ASSERT_SVH

`ifndef SYNTHESIS

// property checked on every rising edge outside reset
`define MISH_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies condition in the next one
`define MISH_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define MISH_ASSERT(lbl, clk, rst_n, prop, msg)

`define MISH_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

// ===== rtl/mish_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mish_pkg
// Shared types, constants and arithmetic helpers of the Mish activation block.
// ----------------------------------------------------------------------------
package mish_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 12;

    // e^-|x| held unsigned with UF fractional bits, 1.0 included
    localparam int UW = 32;
    localparam int UF = 31;
    localparam logic [UW-1:0] U_ONE = UW'(1) << UF;

    // |x| >= 2^INT_BITS gives e^-|x| = 0
    localparam int INT_BITS = 5;

    // fraction is left aligned to FA_W bits and looked up in CHUNK_W bit slices
    localparam int CHUNK_W   = 8;
    localparam int N_CHUNK   = 4;
    localparam int FA_W      = CHUNK_W * N_CHUNK;
    localparam int TAB_DEPTH = 2 ** CHUNK_W;
    localparam int N_FACT    = N_CHUNK + 1;

    // numerator / denominator width (up to 5.0 in Q.31)
    localparam int ND = UW + 2;

    // quotient: one integer bit and RF fractional bits
    localparam int RF = 32;
    localparam int QW = RF + 1;

    typedef logic [UW-1:0] t_exp_tab [TAB_DEPTH];

    typedef struct packed {
        logic vld;
        logic neg;
    } t_ctl;

    // round(e^-(i * 2^sh) * 2^UF) for every index
    function automatic t_exp_tab exp_tab(input int sh);
        t_exp_tab tab;
        real      a;
        for (int i = 0; i < TAB_DEPTH; i++) begin
            a      = $exp(-(real'(i)) * (2.0 ** sh));
            tab[i] = UW'(longint'(a * (2.0 ** UF)));
        end
        return tab;
    endfunction

    // (a * b) / 2^UF, rounded half up
    function automatic logic [UW-1:0] mul_q(input logic [UW-1:0] a,
                                            input logic [UW-1:0] b);
        logic [2*UW-1:0] p;
        p = (2*UW)'(a) * (2*UW)'(b) + ((2*UW)'(1) << (UF - 1));
        return p[UF +: UW];
    endfunction

endpackage

// ===== rtl/mish_activation.sv =====
`timescale 1ns / 1ps
`include "mish_activation_assert.svh"
// ----------------------------------------------------------------------------
// mish_activation
// Streaming Mish activation, x * tanh(softplus(x)), on signed fixed point.
// ----------------------------------------------------------------------------
// One sample per transaction in, one result per transaction out, same Q format
// (Q3.12 by default), rounded to nearest with halves away from zero. A new
// sample is taken every clock while the input skid register is empty; it fills
// when downstream back-pressure holds the pipeline. Latency is set mostly by the
// 33-stage restoring divider (one quotient bit per stage). The other stages:
// magnitude, e^-|x| (table lookup plus three multiply levels), u^2, num/den,
// final product, rounding into the output register. A one-entry skid
// register on the input keeps s_axis_tready a pure register, so downstream
// back-pressure never reaches the input combinationally. The block has no state
// besides the pipeline itself; reset only clears the valid bits.
//
// Math: with u = e^-|x|,
//   x >= 0 : mish = x * (1 + 2u) / (1 + 2u + 2u^2)
//   x <  0 : mish = x * (u^2 + 2u) / (u^2 + 2u + 2)
// u is built as e^-int * e^-frac from 256-entry constant tables (Q.31), then
// the ratio is divided out to 32 fraction bits and multiplied by |x|.
// |x| >= 32 forces u = 0, which returns x itself for positive x and 0 else.
// ----------------------------------------------------------------------------
module mish_activation import mish_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int TDW       = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,

    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [TDW-1:0] s_axis_tdata,   // [DATA_WIDTH-1:0] sample

    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [TDW-1:0] m_axis_tdata    // [DATA_WIDTH-1:0] activation
);

    localparam int PW = DATA_WIDTH + QW;

    // global advance: output slot free or being drained
    logic en;

    // input skid
    logic                  r_skid_vld;
    logic [DATA_WIDTH-1:0] r_skid_data;
    logic                  in_vld;
    logic [DATA_WIDTH-1:0] in_raw;

    // stage A: sign and magnitude
    logic                  n_a_neg;
    logic [DATA_WIDTH-1:0] n_a_mag;
    t_ctl                  r_a_ctl;
    logic [DATA_WIDTH-1:0] r_a_mag;

    // e^-|x|
    t_ctl                  e_ctl;
    logic [DATA_WIDTH-1:0] e_mag;
    logic [UW-1:0]         e_u;

    // stage S: u and u^2
    t_ctl                  r_s_ctl;
    logic [DATA_WIDTH-1:0] r_s_mag;
    logic [UW-1:0]         r_s_u;
    logic [UW-1:0]         r_s_u2;

    // stage N: numerator and denominator
    logic [ND-1:0]         n_num;
    logic [ND-1:0]         n_den;
    t_ctl                  r_n_ctl;
    logic [DATA_WIDTH-1:0] r_n_mag;
    logic [ND-1:0]         r_n_num;
    logic [ND-1:0]         r_n_den;

    // divider output
    t_ctl                  d_ctl;
    logic [DATA_WIDTH-1:0] d_mag;
    logic [QW-1:0]         d_q;

    // stage P: |x| * ratio
    t_ctl                  r_p_ctl;
    logic [DATA_WIDTH-1:0] r_p_mag;
    logic [PW-1:0]         r_p_prod;

    // rounding and sign
    logic [PW-1:0]         n_rnd;
    logic [DATA_WIDTH:0]   n_res_mag;
    logic [DATA_WIDTH-1:0] n_res;

    logic                  r_out_vld;
    logic [DATA_WIDTH-1:0] r_out_data;

    assign en = !r_out_vld || m_axis_tready;

    // ------------------------------------------------------------------
    // input skid: catches one sample while the pipeline is held
    // ------------------------------------------------------------------
    assign s_axis_tready = !r_skid_vld;
    assign in_vld        = r_skid_vld || s_axis_tvalid;
    assign in_raw        = r_skid_vld ? r_skid_data : s_axis_tdata[DATA_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (en) begin
            r_skid_vld <= 1'b0;
        end else if (s_axis_tvalid && !r_skid_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!en && s_axis_tvalid && !r_skid_vld) begin
            r_skid_data <= s_axis_tdata[DATA_WIDTH-1:0];
        end
    end

    // ------------------------------------------------------------------
    // stage A: |x|; the most negative code maps to 2^(DATA_WIDTH-1)
    // ------------------------------------------------------------------
    assign n_a_neg = in_raw[DATA_WIDTH-1];
    assign n_a_mag = n_a_neg ? (DATA_WIDTH'(0) - in_raw) : in_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl.vld <= 1'b0;
        end else if (en) begin
            r_a_ctl.vld <= in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_ctl.neg <= n_a_neg;
            r_a_mag     <= n_a_mag;
        end
    end

    // ------------------------------------------------------------------
    // e^-|x|
    // ------------------------------------------------------------------
    mish_exp #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (r_a_ctl),
        .i_mag   (r_a_mag),
        .o_ctl   (e_ctl),
        .o_mag   (e_mag),
        .o_u     (e_u)
    );

    // ------------------------------------------------------------------
    // stage S: u^2
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_ctl.vld <= 1'b0;
        end else if (en) begin
            r_s_ctl.vld <= e_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s_ctl.neg <= e_ctl.neg;
            r_s_mag     <= e_mag;
            r_s_u       <= e_u;
            r_s_u2      <= mul_q(e_u, e_u);
        end
    end

    // ------------------------------------------------------------------
    // stage N: numerator / denominator, both in Q.31
    // ------------------------------------------------------------------
    always_comb begin
        if (r_s_ctl.neg) begin
            n_num = ND'(r_s_u2) + (ND'(r_s_u) << 1);
            n_den = n_num + (ND'(U_ONE) << 1);
        end else begin
            n_num = ND'(U_ONE) + (ND'(r_s_u) << 1);
            n_den = n_num + (ND'(r_s_u2) << 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_ctl.vld <= 1'b0;
        end else if (en) begin
            r_n_ctl.vld <= r_s_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n_ctl.neg <= r_s_ctl.neg;
            r_n_mag     <= r_s_mag;
            r_n_num     <= n_num;
            r_n_den     <= n_den;
        end
    end

    // ------------------------------------------------------------------
    // ratio num / den, one integer and RF fraction bits
    // ------------------------------------------------------------------
    mish_div #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (r_n_ctl),
        .i_mag   (r_n_mag),
        .i_num   (r_n_num),
        .i_den   (r_n_den),
        .o_ctl   (d_ctl),
        .o_mag   (d_mag),
        .o_q     (d_q)
    );

    // ------------------------------------------------------------------
    // stage P: |x| * ratio
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_ctl.vld <= 1'b0;
        end else if (en) begin
            r_p_ctl.vld <= d_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_ctl.neg <= d_ctl.neg;
            r_p_mag     <= d_mag;
            r_p_prod    <= PW'(d_mag) * PW'(d_q);
        end
    end

    // ------------------------------------------------------------------
    // round magnitude half up, then restore the sign; |result| <= |x|
    // ------------------------------------------------------------------
    assign n_rnd     = (r_p_prod + (PW'(1) << (RF - 1))) >> RF;
    assign n_res_mag = n_rnd[DATA_WIDTH:0];
    assign n_res     = r_p_ctl.neg ? (DATA_WIDTH'(0) - n_res_mag[DATA_WIDTH-1:0])
                                   : n_res_mag[DATA_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_p_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = TDW'(r_out_data);

    `MISH_ASSERT_NEXT(a_skid_drain, i_clk, i_rst_n, r_skid_vld && en, !r_skid_vld, "skid entry not drained on advance")
    `MISH_ASSERT(a_skid_fill, i_clk, i_rst_n, $rose(r_skid_vld) |-> $past(!en), "skid filled while pipeline advanced")
    `MISH_ASSERT(a_res_le_mag, i_clk, i_rst_n, r_p_ctl.vld |-> (n_res_mag <= (DATA_WIDTH+1)'(r_p_mag)), "result magnitude above input magnitude")
    `MISH_ASSERT(a_zero_in, i_clk, i_rst_n, (r_p_ctl.vld && (r_p_mag == '0)) |-> (n_res_mag == '0), "zero sample gave nonzero result")

endmodule

// ===== rtl/mish_exp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mish_exp
// Pipelined e^-|x|: table lookups per bit slice, then a registered product tree.
// ----------------------------------------------------------------------------
module mish_exp import mish_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_ctl                  i_ctl,
    input  logic [DATA_WIDTH-1:0] i_mag,
    output t_ctl                  o_ctl,
    output logic [DATA_WIDTH-1:0] o_mag,
    output logic [UW-1:0]         o_u
);

    localparam int MWW = DATA_WIDTH + FA_W + 1;
    localparam int N_ST = 4;
    localparam t_exp_tab TAB_INT = exp_tab(0);

    logic [MWW-1:0]      n_mag_w;
    logic                n_big;
    logic [INT_BITS-1:0] n_int;
    logic [FA_W-1:0]     n_fa;
    logic [UW-1:0]       n_f [N_FACT];

    logic [UW-1:0]         r_f   [N_FACT];
    logic [UW-1:0]         r_m01;
    logic [UW-1:0]         r_m23;
    logic [UW-1:0]         r_f4a;
    logic [UW-1:0]         r_m03;
    logic [UW-1:0]         r_f4b;
    logic [UW-1:0]         r_u;
    logic                  r_vld [N_ST];
    logic                  r_neg [N_ST];
    logic [DATA_WIDTH-1:0] r_mag [N_ST];

    assign n_mag_w = MWW'(i_mag);
    assign n_big   = |(n_mag_w >> (FRAC_BITS + INT_BITS));
    assign n_int   = n_mag_w[FRAC_BITS +: INT_BITS];
    assign n_fa    = FA_W'(n_mag_w[FRAC_BITS-1:0]) << (FA_W - FRAC_BITS);

    // integer part: forced to zero for large magnitudes
    assign n_f[0] = n_big ? '0 : TAB_INT[CHUNK_W'(n_int)];

    for (genvar c = 0; c < N_CHUNK; c++) begin : g_chunk
        localparam t_exp_tab TAB_FR = exp_tab(CHUNK_W * c - FA_W);
        assign n_f[c+1] = TAB_FR[n_fa[c*CHUNK_W +: CHUNK_W]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < N_ST; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_ctl.vld;
            for (int s = 1; s < N_ST; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0] <= i_ctl.neg;
            r_mag[0] <= i_mag;
            for (int s = 1; s < N_ST; s++) begin
                r_neg[s] <= r_neg[s-1];
                r_mag[s] <= r_mag[s-1];
            end
            r_f   <= n_f;
            r_m01 <= mul_q(r_f[0], r_f[1]);
            r_m23 <= mul_q(r_f[2], r_f[3]);
            r_f4a <= r_f[4];
            r_m03 <= mul_q(r_m01, r_m23);
            r_f4b <= r_f4a;
            r_u   <= mul_q(r_m03, r_f4b);
        end
    end

    assign o_ctl.vld = r_vld[N_ST-1];
    assign o_ctl.neg = r_neg[N_ST-1];
    assign o_mag     = r_mag[N_ST-1];
    assign o_u       = r_u;

endmodule

// ===== rtl/mish_div.sv =====
`timescale 1ns / 1ps
`include "mish_activation_assert.svh"
// ----------------------------------------------------------------------------
// mish_div
// Restoring divider, one quotient bit per pipeline stage, num <= den.
// ----------------------------------------------------------------------------
module mish_div import mish_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_ctl                  i_ctl,
    input  logic [DATA_WIDTH-1:0] i_mag,
    input  logic [ND-1:0]         i_num,
    input  logic [ND-1:0]         i_den,
    output t_ctl                  o_ctl,
    output logic [DATA_WIDTH-1:0] o_mag,
    output logic [QW-1:0]         o_q
);

    localparam int NST = QW;
    localparam int RW  = ND + 1;

    t_ctl                  r_ctl [NST];
    logic [DATA_WIDTH-1:0] r_mag [NST];
    logic [RW-1:0]         r_rem [NST];
    logic [ND-1:0]         r_den [NST];
    logic [QW-1:0]         r_q   [NST];

    for (genvar s = 0; s < NST; s++) begin : g_stage
        logic [RW-1:0]         w_t;
        logic [ND-1:0]         w_den;
        logic [QW-1:0]         w_q;
        logic                  w_vld;
        logic                  w_neg;
        logic [DATA_WIDTH-1:0] w_mag;
        logic                  w_ge;
        logic [RW-1:0]         n_rem;

        if (s == 0) begin : g_first
            assign w_t   = RW'(i_num);
            assign w_den = i_den;
            assign w_q   = '0;
            assign w_vld = i_ctl.vld;
            assign w_neg = i_ctl.neg;
            assign w_mag = i_mag;
        end else begin : g_next
            assign w_t   = {r_rem[s-1][RW-2:0], 1'b0};
            assign w_den = r_den[s-1];
            assign w_q   = r_q[s-1];
            assign w_vld = r_ctl[s-1].vld;
            assign w_neg = r_ctl[s-1].neg;
            assign w_mag = r_mag[s-1];
        end

        assign w_ge  = (w_t >= RW'(w_den));
        assign n_rem = w_ge ? (w_t - RW'(w_den)) : w_t;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[s].vld <= 1'b0;
            end else if (i_en) begin
                r_ctl[s].vld <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctl[s].neg <= w_neg;
                r_mag[s]     <= w_mag;
                r_rem[s]     <= n_rem;
                r_den[s]     <= w_den;
                r_q[s]       <= {w_q[QW-2:0], w_ge};
            end
        end
    end

    assign o_ctl = r_ctl[NST-1];
    assign o_mag = r_mag[NST-1];
    assign o_q   = r_q[NST-1];

    `MISH_ASSERT(a_num_le_den, i_clk, i_rst_n, (i_en && i_ctl.vld) |-> (i_num <= i_den), "div: numerator above denominator")
    `MISH_ASSERT(a_rem_lt_den, i_clk, i_rst_n, r_ctl[NST-1].vld |-> (r_rem[NST-1] < RW'(r_den[NST-1])), "div: final remainder not below denominator")
    `MISH_ASSERT(a_q_le_one, i_clk, i_rst_n, r_ctl[NST-1].vld |-> (r_q[NST-1] <= (QW'(1) << RF)), "div: quotient above one")

endmodule

// ===== test/mish_activation_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mish_activation_test
// Self-checking stream test of the Mish activation block. A driver process
// feeds samples in random bursts from a pending queue. A bit-exact software
// model predicts each accepted sample's activation. A monitor with its own
// stall pattern checks every output transaction in order against that model.
// ----------------------------------------------------------------------------
module mish_activation_test;

    localparam int DW  = mish_pkg::DATA_WIDTH_DEF;
    localparam int FB  = mish_pkg::FRAC_BITS_DEF;
    localparam int TDW = ((DW + 7) / 8) * 8;

    // model arithmetic: unsigned values with 60 fraction bits
    typedef logic [63:0] fx64_t;
    localparam int    PREC      = 60;
    localparam fx64_t PONE      = fx64_t'(1) << PREC;
    localparam int    EXP_TERMS = 26;
    localparam int    BIG_INT   = 32;

    localparam int RANDOM_ITEMS = 1800;
    localparam int HOLD_AT      = 400;     // results seen before the long hold-off
    localparam int HOLD_CYCLES  = 400;     // well past the pipeline depth
    localparam int TAIL_CYCLES  = 100;     // margin past the pipeline latency
    localparam int CYCLE_LIMIT  = 400000;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

    typedef struct {
        logic [DW-1:0] sample;
        bit            drain_first;   // hold this one back until all results are in
    } sample_item_t;

    typedef struct {
        logic [DW-1:0] sample;
        logic [DW-1:0] activation;
    } act_expect_t;

    logic           i_clk;
    logic           i_rst_n       = 1'b0;
    logic           s_axis_tvalid = 1'b0;
    logic           s_axis_tready;
    logic [TDW-1:0] s_axis_tdata  = '0;   // [DW-1:0] sample
    logic           m_axis_tvalid;
    logic           m_axis_tready = 1'b0;
    logic [TDW-1:0] m_axis_tdata;         // [DW-1:0] activation

    sample_item_t sample_q [$];
    act_expect_t  act_expect_q [$];

    int       errors     = 0;
    int       n_results  = 0;
    int       cycles     = 0;
    int       gap_left   = 0;
    int       burst_left = 0;
    int       hold_left  = 0;
    bit       hold_done  = 1'b0;
    int       mode_left  = 0;
    int       pat_cnt    = 0;
    rx_mode_t rx_mode    = RX_OPEN;

    mish_activation dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------------
    // Mish predictor, 60-bit fixed point, rounding as the block specifies
    // ------------------------------------------------------------------------

    // round(a * b / 2^PREC), halves up
    function automatic fx64_t fx_mul(input fx64_t a, input fx64_t b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b} + (128'd1 << (PREC - 1));
        return p[PREC +: 64];
    endfunction

    // e^-f for 0 <= f <= 1 by Taylor series
    function automatic fx64_t exp_frac_neg(input fx64_t f);
        fx64_t sum;
        fx64_t term;
        sum  = PONE;
        term = PONE;
        for (int k = 1; k <= EXP_TERMS; k++) begin
            term = fx_mul(term, f) / fx64_t'(k);
            if (k % 2) sum = sum - term;
            else       sum = sum + term;
        end
        return sum;
    endfunction

    // e^-|x| for magnitude given with FB fraction bits
    function automatic fx64_t exp_mag_neg(input fx64_t mag);
        fx64_t u;
        fx64_t e1;
        int    n;
        if (mag >= (fx64_t'(BIG_INT) << FB)) return '0;
        n  = int'(mag >> FB);
        u  = exp_frac_neg((mag & ((fx64_t'(1) << FB) - 1)) << (PREC - FB));
        e1 = exp_frac_neg(PONE);
        for (int i = 0; i < n; i++) u = fx_mul(u, e1);
        return u;
    endfunction

    // restoring division num / den, num <= den
    function automatic fx64_t frac_divide(input fx64_t num, input fx64_t den);
        fx64_t q;
        fx64_t rem;
        if (den == 0) return '0;
        q   = '0;
        rem = num;
        if (rem >= den) begin
            q   = 1;
            rem = rem - den;
        end
        for (int b = 0; b < PREC; b++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= den) begin
                rem  = rem - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [DW-1:0] mish_predict(input logic [DW-1:0] raw);
        logic         neg;
        fx64_t        mag;
        fx64_t        u;
        fx64_t        u2;
        fx64_t        num;
        fx64_t        den;
        fx64_t        ratio;
        fx64_t        res;
        logic [127:0] p;
        neg = raw[DW-1];
        // most negative sample: magnitude 2^(DW-1) still fits in 64 bits
        mag = neg ? ((fx64_t'(1) << DW) - fx64_t'(raw)) : fx64_t'(raw);
        if (mag == 0) return '0;
        u  = exp_mag_neg(mag);
        u2 = fx_mul(u, u);
        if (neg) begin
            num = u2 + (u << 1);
            den = num + (PONE << 1);
        end else begin
            num = PONE + (u << 1);
            den = num + (u2 << 1);
        end
        ratio = frac_divide(num, den);
        p     = {64'd0, mag} * {64'd0, ratio} + (128'd1 << (PREC - 1));
        res   = p[PREC +: 64];
        if (neg) res = -res;
        return res[DW-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // clock, run limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: run limit reached, %0d results pending", $time,
                     act_expect_q.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // driver: bursts from sample_q, prediction taken at each accepted transaction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_proc
        sample_item_t nxt;
        act_expect_t  exp_item;
        logic         take;
        logic         offer;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else begin
            take = s_axis_tvalid && s_axis_tready;
            if (take) begin
                exp_item.sample     = s_axis_tdata[DW-1:0];
                exp_item.activation = mish_predict(s_axis_tdata[DW-1:0]);
                act_expect_q.push_back(exp_item);
            end
            // tvalid stays up until the item is taken
            if (!s_axis_tvalid || take) begin
                offer = 1'b0;
                // during the receiver hold-off keep pushing so the pipe backs up
                if (gap_left != 0 && hold_left == 0) begin
                    gap_left--;
                end else if (sample_q.size() != 0 &&
                             !(sample_q[0].drain_first && act_expect_q.size() != 0)) begin
                    nxt   = sample_q.pop_front();
                    offer = 1'b1;
                    s_axis_tdata <= TDW'(nxt.sample);
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end
                s_axis_tvalid <= offer;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: in-order compare, receiver stall pattern, one long hold-off
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : sink_proc
        act_expect_t want;
        logic        rdy;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                if (act_expect_q.size() == 0) begin
                    errors++;
                    $display("%0t: result %h with nothing expected", $time,
                             m_axis_tdata[DW-1:0]);
                end else begin
                    want = act_expect_q.pop_front();
                    if (m_axis_tdata[DW-1:0] !== want.activation) begin
                        errors++;
                        $display("%0t: activation of sample %h expected %h actual %h",
                                 $time, want.sample, want.activation,
                                 m_axis_tdata[DW-1:0]);
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (!hold_done && n_results >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                rdy       = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 300);
                end else begin
                    mode_left--;
                end
                case (rx_mode)
                    RX_OPEN:   rdy = 1'b1;
                    RX_COIN:   rdy = $urandom_range(0, 1);
                    RX_SPARSE: rdy = ($urandom_range(0, 9) == 0);
                    default:   rdy = (pat_cnt % 5) < 3;
                endcase
                pat_cnt++;
            end
            m_axis_tready <= rdy;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus, reset, end of run
    // ------------------------------------------------------------------------
    task automatic queue_sample(input logic [DW-1:0] s, input bit drain);
        sample_item_t it;
        it.sample      = s;
        it.drain_first = drain;
        sample_q.push_back(it);
    endtask

    initial begin : main_proc
        int corner [];
        int sel;
        int v;
        // zero, +-1 LSB, full scale both ways, +-1.0, +-0.5, the curve's
        // minimum near -1.19, alternating bit patterns, fraction-only values
        corner = '{0, 1, -1, 2, -2, 32767, -32768, -32767, 4096, -4096,
                   2048, -2048, -4875, -4876, 21845, -21846, 4095, -4097,
                   8191, -8192, 24576, -24576};
        foreach (corner[i]) queue_sample(DW'(corner[i]), 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sel = $urandom_range(0, 9);
            case (sel)
                0, 1, 2, 3: v = $urandom_range(0, 65535);
                4, 5, 6:    v = $urandom_range(0, 16383) - 8192;   // -2 <= x < 2
                7:          v = $urandom_range(0, 3000) - 6000;    // around the minimum
                8:          v = ($urandom_range(0, 1) ? 32767 : -32768) +
                                ($urandom_range(0, 1) ? -$urandom_range(0, 63)
                                                      : $urandom_range(0, 63));
                default:    v = $urandom_range(0, 32) - 16;
            endcase
            // pause the sender for a full drain between phases
            queue_sample(DW'(v), n == 0 || n == 600 || n == 1300);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sample_q.size() != 0 || s_axis_tvalid || act_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (act_expect_q.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time,
                     act_expect_q.size());
        end
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
